[hdl/xml_entity_unescaper_top_assert.svh]
// Assertion macros for the entity unescaper.
// Every check is sampled on i_clk and is off while i_rst_n is low.
`ifndef XML_ENTITY_UNESCAPER_TOP_ASSERT_SVH
`define XML_ENTITY_UNESCAPER_TOP_ASSERT_SVH

// Same-cycle implication.
`define XEU_ASSERT_IMP(lbl, ant, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ant) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define XEU_ASSERT_NXT(lbl, ant, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ant) |=> (cons)) \
        else $error(msg);

`endif

[hdl/xeu_pkg.sv]
`default_nettype none

package xeu_pkg;

    localparam int HOLD_DEPTH = 5;  // held prefix bytes
    localparam int MAX_RES    = 6;  // results one input byte can cause
    localparam int ENT_KINDS  = 5;

    localparam logic [7:0] CH_AMP = 8'h26;  // '&'

    // Entity spellings, padded with zeros: &quot; &apos; &lt; &gt; &amp;
    localparam logic [7:0] ENT_TEXT [ENT_KINDS][MAX_RES] = '{
        '{8'h26, 8'h71, 8'h75, 8'h6f, 8'h74, 8'h3b},
        '{8'h26, 8'h61, 8'h70, 8'h6f, 8'h73, 8'h3b},
        '{8'h26, 8'h6c, 8'h74, 8'h3b, 8'h00, 8'h00},
        '{8'h26, 8'h67, 8'h74, 8'h3b, 8'h00, 8'h00},
        '{8'h26, 8'h61, 8'h6d, 8'h70, 8'h3b, 8'h00}
    };
    localparam logic [2:0] ENT_LEN  [ENT_KINDS] = '{3'd6, 3'd6, 3'd4, 3'd4, 3'd5};
    localparam logic [7:0] ENT_CHAR [ENT_KINDS] = '{8'h22, 8'h27, 8'h3c, 8'h3e, 8'h26};

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } t_in;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
    } t_out;

    // One queued job: up to six bytes to emit, in order.
    typedef struct packed {
        logic [MAX_RES-1:0][7:0] bytes;
        logic [2:0]              cnt;
        logic                    last;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

`default_nettype wire

[hdl/xeu_front.sv]
`default_nettype none

module xeu_front (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_accept,
    input  wire xeu_pkg::t_in i_in,
    output xeu_pkg::t_job     o_job
);

    logic [7:0] r_pend [xeu_pkg::HOLD_DEPTH];
    logic [2:0] r_cnt;
    logic [2:0] n_cnt;

    logic [7:0] cand [xeu_pkg::MAX_RES];
    logic [2:0] len;
    logic [xeu_pkg::ENT_KINDS-1:0] ok;
    logic [xeu_pkg::ENT_KINDS-1:0] hit;
    logic [7:0] ch;
    logic       prefix;
    logic       wr_ext;
    logic       wr_first;

    always_comb begin
        for (int i = 0; i < xeu_pkg::HOLD_DEPTH; i++) begin
            cand[i] = (3'(i) < r_cnt) ? r_pend[i] : i_in.in_byte;
        end
        cand[xeu_pkg::MAX_RES-1] = i_in.in_byte;
        len = r_cnt + 3'd1;

        ch = 8'h00;
        for (int k = 0; k < xeu_pkg::ENT_KINDS; k++) begin
            ok[k] = (len <= xeu_pkg::ENT_LEN[k]);
            for (int i = 0; i < xeu_pkg::MAX_RES; i++) begin
                if (3'(i) < len && cand[i] != xeu_pkg::ENT_TEXT[k][i]) begin
                    ok[k] = 1'b0;
                end
            end
            hit[k] = ok[k] && (len == xeu_pkg::ENT_LEN[k]);
            if (hit[k]) begin
                ch = ch | xeu_pkg::ENT_CHAR[k];
            end
        end
        prefix = |(ok & ~hit);

        for (int i = 0; i < xeu_pkg::MAX_RES; i++) begin
            o_job.bytes[i] = cand[i];
        end
        o_job.last = i_in.in_last;
        wr_ext     = 1'b0;
        wr_first   = 1'b0;

        if (|hit) begin
            o_job.bytes[0] = ch;
            o_job.cnt      = 3'd1;
            n_cnt          = 3'd0;
        end else if (prefix && r_cnt < 3'(xeu_pkg::HOLD_DEPTH)) begin
            // still a prefix: hold, or flush all on the last byte
            if (i_in.in_last) begin
                o_job.cnt = len;
                n_cnt     = 3'd0;
            end else begin
                o_job.cnt = 3'd0;
                n_cnt     = len;
                wr_ext    = 1'b1;
            end
        end else if (i_in.in_byte == xeu_pkg::CH_AMP && !i_in.in_last) begin
            // mismatch on a fresh '&': release held bytes, open a new run
            o_job.cnt = r_cnt;
            n_cnt     = 3'd1;
            wr_first  = 1'b1;
        end else begin
            o_job.cnt = len;
            n_cnt     = 3'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 3'd0;
        end else if (i_accept) begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < xeu_pkg::HOLD_DEPTH; i++) begin
            if (i_accept && ((wr_ext && 3'(i) == r_cnt) || (wr_first && i == 0))) begin
                r_pend[i] <= i_in.in_byte;
            end
        end
    end

endmodule

`default_nettype wire

[hdl/xeu_jobq.sv]
`default_nettype none

module xeu_jobq #(
    parameter int DEPTH = 4
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_enq,
    input  wire xeu_pkg::t_job i_job,
    input  wire logic          i_deq,
    output xeu_pkg::t_job      o_head,
    output xeu_pkg::t_q_stat   o_stat
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    xeu_pkg::t_job r_mem [DEPTH];
    logic [AW-1:0] r_wptr;
    logic [AW-1:0] r_rptr;
    logic [CW-1:0] r_count;
    logic [AW-1:0] n_wptr;
    logic [AW-1:0] n_rptr;

    always_comb begin
        n_wptr = (r_wptr == AW'(DEPTH - 1)) ? '0 : r_wptr + AW'(1);
        n_rptr = (r_rptr == AW'(DEPTH - 1)) ? '0 : r_rptr + AW'(1);
        o_head       = r_mem[r_rptr];
        o_stat.full  = (r_count == CW'(DEPTH));
        o_stat.empty = (r_count == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_enq) begin
                r_wptr <= n_wptr;
            end
            if (i_deq) begin
                r_rptr <= n_rptr;
            end
            if (i_enq && !i_deq) begin
                r_count <= r_count + CW'(1);
            end else if (!i_enq && i_deq) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_enq) begin
            r_mem[r_wptr] <= i_job;
        end
    end

endmodule

`default_nettype wire

[hdl/xeu_back.sv]
`default_nettype none

module xeu_back (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire xeu_pkg::t_job   i_head,
    input  wire xeu_pkg::t_q_stat i_q_stat,
    output logic                 o_deq,
    input  wire logic            i_pop,
    output logic                 o_empty,
    output xeu_pkg::t_out        o_out
);

    logic          r_valid;
    xeu_pkg::t_out r_out;
    logic [2:0]    r_idx;
    logic          load;
    logic          at_end;

    always_comb begin
        load    = !i_q_stat.empty && (!r_valid || i_pop);
        at_end  = (r_idx == i_head.cnt - 3'd1);
        o_deq   = load && at_end;
        o_empty = !r_valid;
        o_out   = r_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 3'd0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_idx   <= at_end ? 3'd0 : r_idx + 3'd1;
            end else if (i_pop) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out.out_byte <= i_head.bytes[r_idx];
            r_out.out_last <= i_head.last && at_end;
        end
    end

endmodule

`default_nettype wire

[hdl/xml_entity_unescaper_top.sv]
// Path: results queue as jobs in a QUEUE_DEPTH-job queue, then pass the output register.
// Throughput: one input byte per cycle while the queue has room, one result byte per
//   cycle while popped; a byte may release up to six results, drained one a cycle.
// Reset (i_rst_n low, synchronous): hold count, queue pointers and output valid clear;
//   no clearing pass, the block takes input as soon as reset is released.
`default_nettype none

module xml_entity_unescaper_top #(
    parameter int QUEUE_DEPTH = 4   // jobs between front and back, 2..8
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         push,
    output logic              full,
    input  wire xeu_pkg::t_in i_in,
    output logic              empty,
    input  wire logic         pop,
    output xeu_pkg::t_out     o_out
);

`include "xml_entity_unescaper_top_assert.svh"

    xeu_pkg::t_job    job;
    xeu_pkg::t_job    head;
    xeu_pkg::t_q_stat q_stat;
    logic             accept;
    logic             enq;
    logic             deq;

    // Input transaction completes whenever the job queue has room; a byte that
    // only extends a held run produces an empty job and is not queued.
    assign full   = q_stat.full;
    assign accept = push && !q_stat.full;
    assign enq    = accept && (job.cnt != 3'd0);

    // Front: holds the entity prefix and classifies each byte into a job.
    xeu_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_in     (i_in),
        .o_job    (job)
    );

    // Short job queue decouples a six-byte burst from the input side.
    xeu_jobq #(
        .DEPTH (QUEUE_DEPTH)
    ) u_jobq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_enq   (enq),
        .i_job   (job),
        .i_deq   (deq),
        .o_head  (head),
        .o_stat  (q_stat)
    );

    // Back: serializes each job into result transactions, one byte per cycle while popped.
    xeu_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (head),
        .i_q_stat (q_stat),
        .o_deq    (deq),
        .i_pop    (pop),
        .o_empty  (empty),
        .o_out    (o_out)
    );

    // A last byte always yields at least one result.
    `XEU_ASSERT_IMP(a_last_job_nonempty, accept && i_in.in_last, enq, "last byte queued no job")
    // Queue cannot report full and empty together.
    `XEU_ASSERT_IMP(a_q_sane, 1'b1, !(q_stat.full && q_stat.empty), "queue full and empty")
    // Pending work with an idle output register must show up next cycle.
    `XEU_ASSERT_NXT(a_back_loads, !q_stat.empty && empty, !empty, "back stalled while idle")

endmodule

`default_nettype wire

[sim/xml_entity_unescaper_checker.sv]
`timescale 1ns / 1ps

module xml_entity_unescaper_checker (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire logic          i_full,
    input  wire xeu_pkg::t_in  i_in,
    input  wire logic          i_empty,
    input  wire logic          i_pop,
    input  wire xeu_pkg::t_out i_out,
    output int                 o_errors,
    output int                 o_waiting
);

    typedef enum logic [1:0] {NO_ENTITY, PARTIAL_ENTITY, WHOLE_ENTITY} t_verdict;

    localparam int         HOLD_MAX  = 5;
    localparam logic [7:0] AMPERSAND = 8'h26;

    string      entity_spell [5] = '{"&quot;", "&apos;", "&lt;", "&gt;", "&amp;"};
    logic [7:0] entity_char  [5] = '{8'h22, 8'h27, 8'h3c, 8'h3e, 8'h26};

    logic [7:0]    held [HOLD_MAX];
    int            held_cnt = 0;
    int            err_cnt  = 0;
    xeu_pkg::t_out decoded_q [$];
    xeu_pkg::t_out want;

    assign o_errors = err_cnt;

    // Prefix test of the first len bytes against every entity spelling.
    function automatic t_verdict classify(input logic [7:0] cand [6], input int len,
                                          output logic [7:0] ch);
        t_verdict verdict;
        bit       same;
        verdict = NO_ENTITY;
        ch      = '0;
        for (int k = 0; k < 5; k++) begin
            if (len <= entity_spell[k].len()) begin
                same = 1'b1;
                for (int i = 0; i < len; i++)
                    if (cand[i] != entity_spell[k][i]) same = 1'b0;
                if (same) begin
                    if (len == entity_spell[k].len()) begin
                        ch = entity_char[k];
                        return WHOLE_ENTITY;
                    end
                    verdict = PARTIAL_ENTITY;
                end
            end
        end
        return verdict;
    endfunction

    // Queues the unescaped bytes caused by one accepted input byte.
    task automatic decode_byte(input xeu_pkg::t_in item);
        logic [7:0] cand [6];
        logic [7:0] outs [6];
        logic [7:0] ch;
        int         n;
        bit         taken;
        t_verdict   verdict;
        n     = 0;
        taken = 1'b0;
        for (int i = 0; i < 6; i++) cand[i] = '0;
        if (held_cnt > 0) begin
            for (int i = 0; i < held_cnt; i++) cand[i] = held[i];
            cand[held_cnt] = item.in_byte;
            verdict = classify(cand, held_cnt + 1, ch);
            if (verdict == WHOLE_ENTITY) begin
                held_cnt = 0;
                outs[n]  = ch;
                n++;
                taken = 1'b1;
            end else if (verdict == PARTIAL_ENTITY && held_cnt < HOLD_MAX) begin
                held[held_cnt] = item.in_byte;
                held_cnt++;
                taken = 1'b1;
            end else begin
                for (int i = 0; i < held_cnt; i++) begin
                    outs[n] = held[i];
                    n++;
                end
                held_cnt = 0;
            end
        end
        if (!taken) begin
            if (item.in_byte == AMPERSAND) begin
                held[0]  = item.in_byte;
                held_cnt = 1;
            end else begin
                outs[n] = item.in_byte;
                n++;
            end
        end
        if (item.in_last) begin
            for (int i = 0; i < held_cnt; i++) begin
                outs[n] = held[i];
                n++;
            end
            held_cnt = 0;
        end
        for (int i = 0; i < n; i++)
            decoded_q.push_back(xeu_pkg::t_out'{out_byte: outs[i],
                                                out_last: item.in_last && (i == n - 1)});
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            held_cnt = 0;
            decoded_q.delete();
        end else begin
            // output side first: a result never leaves on the edge its input came in
            if (i_pop && !i_empty) begin
                if (decoded_q.size() == 0) begin
                    $display("%0t: unexpected result byte %02h last %0b",
                             $time, i_out.out_byte, i_out.out_last);
                    err_cnt++;
                end else begin
                    want = decoded_q.pop_front();
                    if (i_out.out_byte !== want.out_byte
                        || i_out.out_last !== want.out_last) begin
                        $display("%0t: mismatch, expected byte %02h last %0b, got byte %02h last %0b",
                                 $time, want.out_byte, want.out_last,
                                 i_out.out_byte, i_out.out_last);
                        err_cnt++;
                    end
                end
            end
            if (i_push && !i_full) decode_byte(i_in);
        end
        o_waiting <= decoded_q.size();
    end

endmodule

[sim/xml_entity_unescaper_top_tb.sv]
`timescale 1ns / 1ps

module xml_entity_unescaper_top_tb;

    // Watchdog limit, far above the length of a correct run.
    localparam int CYCLE_LIMIT   = 200000;
    localparam int PHASE_ITEMS   = 75;
    localparam int TAIL_CYCLES   = 20;

    // Idle percentages per phase: none, sender only, receiver only, both.
    localparam int SEND_IDLE  [4] = '{0, 71, 0, 31};
    localparam int RECV_STALL [4] = '{0, 0, 71, 31};

    logic          i_clk   = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          push    = 1'b0;
    logic          pop     = 1'b0;
    xeu_pkg::t_in  din     = '0;
    logic          full;
    logic          empty;
    xeu_pkg::t_out dout;

    int errors;
    int waiting;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int cycles         = 0;
    int items_sent     = 0;

    string entity_spell [5] = '{"&quot;", "&apos;", "&lt;", "&gt;", "&amp;"};

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    xml_entity_unescaper_top i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .push    (push),
        .full    (full),
        .i_in    (din),
        .empty   (empty),
        .pop     (pop),
        .o_out   (dout)
    );

    // Watches both channels, predicts every result and counts mismatches.
    xml_entity_unescaper_checker i_checker (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .i_full    (full),
        .i_in      (din),
        .i_empty   (empty),
        .i_pop     (pop),
        .i_out     (dout),
        .o_errors  (errors),
        .o_waiting (waiting)
    );

    // Receiver: pop is redrawn every edge, so stalls land on every phase of a burst.
    always @(posedge i_clk) begin
        pop <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Watchdog: a hung handshake or a lost result ends the run here.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // One input transaction. push stays high straight into the next byte unless an
    // idle gap is drawn, so a valid is never dropped and raised in the same step.
    task automatic send_byte(input logic [7:0] b, input logic lst);
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push <= 1'b1;
        din  <= xeu_pkg::t_in'{in_byte: b, in_last: lst};
        @(posedge i_clk);
        // full read here is the value the DUT saw at this edge
        while (full) @(posedge i_clk);
        items_sent++;
    endtask

    task automatic send_text(input string s, input logic lst);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], lst && (i == s.len() - 1));
    endtask

    // Stop sending and wait for every predicted result to come out. The extra edge
    // lets the checker's count catch up with the last accepted transaction.
    task automatic drain();
        push <= 1'b0;
        @(posedge i_clk);
        while (waiting != 0) @(posedge i_clk);
    endtask

    // Well-formed entities, chosen at random, in three of ten tokens; the rest is plain bytes,
    // stray ampersands and entities cut short by a random byte.
    task automatic send_random_token(input logic lst);
        int kind;
        int k;
        int cut;
        kind = $urandom_range(9);
        k    = $urandom_range(4);
        if (kind <= 3) begin
            send_byte(8'($urandom_range(255)), lst);
        end else if (kind <= 6) begin
            send_text(entity_spell[k], lst);
        end else if (kind <= 8) begin
            cut = $urandom_range(entity_spell[k].len() - 1, 1);
            send_text(entity_spell[k].substr(0, cut - 1), 1'b0);
            send_byte(8'($urandom_range(255)), lst);
        end else begin
            send_byte(8'h26, lst);
        end
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part.
        // Longest held run broken by a new ampersand, which then opens a run of its own.
        send_text("&quot&apos;", 1'b0);
        send_text("&amp;", 1'b0);
        send_text("&lt;", 1'b0);
        // Held run broken by a last byte; byte extremes on both flag values.
        send_byte(8'h00, 1'b0);
        send_text("&am", 1'b0);
        send_byte(8'hff, 1'b1);
        // Entity completed by the last byte: decoded char carries the last flag.
        send_text("&gt;", 1'b1);
        // Lone ampersand as the last byte: flushed out, flagged last.
        send_byte(8'h26, 1'b1);

        // Sender holds off until every outstanding result has been popped.
        drain();

        // Random part, one phase per idle pattern.
        for (int p = 0; p < 4; p++) begin
            send_idle_pct  = SEND_IDLE[p];
            recv_stall_pct = RECV_STALL[p];
            items_sent     = 0;
            while (items_sent < PHASE_ITEMS)
                send_random_token($urandom_range(7) == 0);
            if (p == 1) drain();
        end
        // Close the final string so nothing stays held.
        send_byte(8'($urandom_range(255)), 1'b1);

        recv_stall_pct = 0;
        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
